// ===== rtl/core/atou_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII to unsigned integer parser: shared types and constants
// Word layouts of the character and result channels, widths, character
// codes and status codes used by the parser.
// ----------------------------------------------------------------------------
package atou_pkg;

    // Field widths.
    localparam int VALUE_WIDTH  = 64;
    localparam int OFFSET_WIDTH = 16;
    localparam int BASE_WIDTH   = 6;
    localparam int CHAR_WIDTH   = 8;
    localparam int STATUS_WIDTH = 2;

    // Reset value of the base register.
    localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;

    // Radix values with a special role.
    localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_ONE   = 6'd1;
    localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_WIDTH-1:0] BASE_LIMIT = 6'd36;

    // Character codes.
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;

    // Digit value given to characters below the letter A that are no decimal digit.
    localparam logic [CHAR_WIDTH-1:0] DIGIT_NONE = 8'd99;

    // Result status codes.
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_NODIGITS = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW = 2'd2;

    // One character word.
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_code;
        logic                  string_start;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  value;
        logic [OFFSET_WIDTH-1:0] stop_offset;
        logic [STATUS_WIDTH-1:0] status;
    } result_t;

    // Value of a character as a digit, following the C library rules.
    function automatic logic [CHAR_WIDTH-1:0] digit_value(input logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] d;
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                d = c - CHAR_ZERO;
            end
            else if (c >= CHAR_LOWER_A)
            begin
                d = c - (CHAR_LOWER_A - 8'd10);
            end
            else if (c >= CHAR_UPPER_A)
            begin
                d = c - (CHAR_UPPER_A - 8'd10);
            end
            else
            begin
                d = DIGIT_NONE;
            end
            return d;
        end
    endfunction

    // Offset increment that saturates at the top of the offset range.
    function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] p);
        logic [OFFSET_WIDTH-1:0] r;
        begin
            if (&p)
            begin
                r = p;
            end
            else
            begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/ascii_to_unsigned_integer_parser.sv =====
// ----------------------------------------------------------------------------
// ASCII to unsigned integer parser
// Streams characters of strings and converts each string to an unsigned integer
// like strtoumax, one character per cycle unless a stalled result holds it up.
// ----------------------------------------------------------------------------
// Usage:
// Characters arrive one per word on the item channel; string_start marks
// the first character of each string and restarts the parser. A NUL byte,
// or any character that is not a digit of the radix, ends the number and
// produces one word on the result channel: the value, the offset just past
// the last digit and a status. Characters after that are ignored until the
// next string_start. The cfg channel writes the radix (0 selects detection
// from the prefix); it is sampled when a string starts. The user must write
// it only while the parser is idle; the block itself does not enforce this.
// Timing: a character word goes into an input register; from there the digit
// update (one 64 by 6 bit multiply-add with an exact overflow check) writes
// the parser state and the result register, so a result passes through both
// registers. One character word is accepted in every cycle while no waiting
// result is stalled.
// Reset clears the parser to idle and sets the radix to ten. When the
// result receiver stalls, a waiting result holds; the input register then
// fills and item_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module ascii_to_unsigned_integer_parser
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                item_valid,
    output logic                                item_ready,
    input  atou_pkg::item_t                     item_data,

    output logic                                result_valid,
    input  logic                                result_ready,
    output atou_pkg::result_t                   result_data,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [atou_pkg::BASE_WIDTH-1:0]     cfg_data
);

    // Parser phase codes.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_LEAD     = 3'd1;
    localparam logic [2:0] PH_NUMSTART = 3'd2;
    localparam logic [2:0] PH_ZERO     = 3'd3;
    localparam logic [2:0] PH_DIGITS   = 3'd4;

    localparam int VW = atou_pkg::VALUE_WIDTH;
    localparam int OW = atou_pkg::OFFSET_WIDTH;
    localparam int BW = atou_pkg::BASE_WIDTH;
    localparam int PW = VW + BW + 1;

    // Configuration and input registers.
    logic [BW-1:0]          number_base_reg;
    logic                   in_valid_reg;
    atou_pkg::item_t        in_data_reg;
    logic                   in_advance;

    // Parser state.
    logic [2:0]             phase_reg,     phase_next;
    logic [BW-1:0]          base_reg,      base_next;
    logic [VW-1:0]          acc_reg,       acc_next;
    logic                   minus_reg,     minus_next;
    logic                   dig_reg,       dig_next;
    logic                   ovf_reg,       ovf_next;
    logic [OW-1:0]          pos_reg,       pos_next;
    logic [OW-1:0]          last_reg,      last_next;

    // Result register.
    logic                   result_valid_reg;
    atou_pkg::result_t      result_data_reg, result_data_next;
    logic                   emit;

    // Per-character working signals.
    logic [2:0]             ph;
    logic [BW-1:0]          base_cur;
    logic [VW-1:0]          acc_cur;
    logic                   minus_cur;
    logic                   dig_cur;
    logic                   ovf_cur;
    logic [OW-1:0]          pos_cur;
    logic [OW-1:0]          last_cur;
    logic [7:0]             c;
    logic [7:0]             digit;
    logic                   do_take;
    logic                   do_start_num;
    logic                   digit_ok;
    logic [PW-1:0]          mac;

    // The configuration register is always ready.
    assign cfg_ready = 1'b1;

    // The input stage moves on whenever the result register can take a word.
    assign in_advance   = in_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || in_advance;
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    assign c     = in_data_reg.char_code;
    assign digit = atou_pkg::digit_value(c);

    // Radix register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= atou_pkg::BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            number_base_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_data_reg <= item_data;
        end
    end

    // Parse one character: restart on a string start, then step the phase.
    always_comb
    begin
        if (in_data_reg.string_start)
        begin
            ph        = PH_LEAD;
            base_cur  = number_base_reg;
            acc_cur   = '0;
            minus_cur = 1'b0;
            dig_cur   = 1'b0;
            ovf_cur   = 1'b0;
            pos_cur   = '0;
            last_cur  = '0;
        end
        else
        begin
            ph        = phase_reg;
            base_cur  = base_reg;
            acc_cur   = acc_reg;
            minus_cur = minus_reg;
            dig_cur   = dig_reg;
            ovf_cur   = ovf_reg;
            pos_cur   = pos_reg;
            last_cur  = last_reg;
        end

        phase_next   = ph;
        base_next    = base_cur;
        acc_next     = acc_cur;
        minus_next   = minus_cur;
        dig_next     = dig_cur;
        ovf_next     = ovf_cur;
        last_next    = last_cur;
        pos_next     = pos_cur;
        do_take      = 1'b0;
        do_start_num = 1'b0;
        emit         = 1'b0;

        case (ph)
            PH_LEAD:
            begin
                if (c == atou_pkg::CHAR_SPACE ||
                    c inside {[atou_pkg::CHAR_TAB:atou_pkg::CHAR_CR]})
                begin
                    phase_next = PH_LEAD;
                end
                else if (c == atou_pkg::CHAR_MINUS)
                begin
                    minus_next = 1'b1;
                    phase_next = PH_NUMSTART;
                end
                else if (c == atou_pkg::CHAR_PLUS)
                begin
                    phase_next = PH_NUMSTART;
                end
                else
                begin
                    do_start_num = 1'b1;
                end
            end
            PH_NUMSTART:
            begin
                do_start_num = 1'b1;
            end
            PH_ZERO:
            begin
                phase_next = PH_DIGITS;
                if (c == atou_pkg::CHAR_LOWER_X || c == atou_pkg::CHAR_UPPER_X)
                begin
                    base_next = atou_pkg::BASE_HEX;
                end
                else
                begin
                    if (base_cur == atou_pkg::BASE_AUTO)
                    begin
                        base_next = atou_pkg::BASE_OCT;
                    end
                    do_take = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                do_take = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // First character of the number: a leading zero may open a prefix.
        if (do_start_num)
        begin
            if (c == atou_pkg::CHAR_ZERO &&
                (base_cur == atou_pkg::BASE_AUTO || base_cur == atou_pkg::BASE_HEX))
            begin
                dig_next   = 1'b1;
                last_next  = atou_pkg::sat_inc(pos_cur);
                phase_next = PH_ZERO;
            end
            else
            begin
                if (base_cur == atou_pkg::BASE_AUTO)
                begin
                    base_next = atou_pkg::BASE_DEC;
                end
                phase_next = PH_DIGITS;
                do_take    = 1'b1;
            end
        end

        // Digit accumulation with an exact overflow check on the widened sum.
        digit_ok = (base_next >= atou_pkg::BASE_ONE) && (base_next <= atou_pkg::BASE_LIMIT) &&
                   (digit < 8'(base_next));
        mac = {{(BW + 1){1'b0}}, acc_cur} * PW'(base_next) + PW'(digit);
        if (do_take)
        begin
            if (digit_ok)
            begin
                if (!ovf_cur)
                begin
                    if (|mac[PW-1:VW])
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = mac[VW-1:0];
                    end
                end
                dig_next  = 1'b1;
                last_next = atou_pkg::sat_inc(pos_cur);
            end
            else
            begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end
        end

        if (ph != PH_IDLE)
        begin
            pos_next = atou_pkg::sat_inc(pos_cur);
        end

        // Result word for a finished number.
        if (!dig_next)
        begin
            result_data_next.value       = '0;
            result_data_next.stop_offset = '0;
            result_data_next.status      = atou_pkg::STATUS_NODIGITS;
        end
        else if (ovf_next)
        begin
            result_data_next.value       = '1;
            result_data_next.stop_offset = last_next;
            result_data_next.status      = atou_pkg::STATUS_OVERFLOW;
        end
        else
        begin
            result_data_next.value       = minus_next ? (VW'(0) - acc_next) : acc_next;
            result_data_next.stop_offset = last_next;
            result_data_next.status      = atou_pkg::STATUS_OK;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            base_reg  <= '0;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            dig_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
            last_reg  <= '0;
        end
        else if (in_advance)
        begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            dig_reg   <= dig_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (in_advance && emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && emit)
        begin
            result_data_reg <= result_data_next;
        end
    end

endmodule

// ===== tb/ascii_to_unsigned_integer_parser_tb.sv =====
// ----------------------------------------------------------------------------
// ASCII to unsigned integer parser: testbench
// Streams strings one character word at a time through the parser, predicts
// each result word from a cycle-free model of the parse and compares the
// words that come out, field by field, against those predictions. The radix
// register is stepped through auto-detect, the valid extremes and invalid
// settings, with idle and stall gaps on both channels.
// ----------------------------------------------------------------------------
module ascii_to_unsigned_integer_parser_tb;

    import atou_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to let the parser settle once no result word is outstanding.
    localparam int SETTLE_CYCLES = 8;
    // Minimum count of random character words per radix setting.
    localparam int RANDOM_WORDS_PER_BASE = 8;
    // Mismatch lines printed before the log goes quiet.
    localparam int PRINT_LIMIT = 100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_AFTER_SIGN,
        ST_ZERO,
        ST_DIGITS
    } parse_state_e;

    // Tracks the parse of the character stream and holds the result words
    // that the parser still owes.
    class number_scoreboard;
        logic [BASE_WIDTH-1:0]   base_reg;
        parse_state_e            state;
        logic [BASE_WIDTH-1:0]   radix;
        logic [VALUE_WIDTH-1:0]  acc;
        bit                      negative;
        bit                      got_digit;
        bit                      overflowed;
        logic [OFFSET_WIDTH-1:0] char_pos;
        logic [OFFSET_WIDTH-1:0] stop_pos;
        result_t                 owed_results[$];
        int unsigned             error_count;

        function new();
            base_reg    = BASE_RESET;
            state       = ST_IDLE;
            radix       = '0;
            acc         = '0;
            negative    = 1'b0;
            got_digit   = 1'b0;
            overflowed  = 1'b0;
            char_pos    = '0;
            stop_pos    = '0;
            error_count = 0;
        endfunction

        function void set_base(input logic [BASE_WIDTH-1:0] b);
            base_reg = b;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        task report(input string msg);
            if (error_count < PRINT_LIMIT)
            begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
            error_count++;
        endtask

        function logic [OFFSET_WIDTH-1:0] sat_step(input logic [OFFSET_WIDTH-1:0] p);
            return (p == '1) ? p : p + 1'b1;
        endfunction

        // Accumulate one digit, or close the string when the character is
        // no digit of the current radix.
        function void take_digit(input logic [CHAR_WIDTH-1:0] c,
                                 input logic [OFFSET_WIDTH-1:0] pos);
            logic [CHAR_WIDTH-1:0] d;
            logic [71:0]           wide;
            result_t               r;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                d = c - CHAR_ZERO;
            end
            else if (c >= CHAR_LOWER_A)
            begin
                d = c - CHAR_LOWER_A + 8'd10;
            end
            else if (c >= CHAR_UPPER_A)
            begin
                d = c - CHAR_UPPER_A + 8'd10;
            end
            else
            begin
                d = DIGIT_NONE;
            end
            if (radix < BASE_ONE || radix > BASE_LIMIT || d >= radix)
            begin
                if (!got_digit)
                begin
                    r.value       = '0;
                    r.stop_offset = '0;
                    r.status      = STATUS_NODIGITS;
                end
                else if (overflowed)
                begin
                    r.value       = '1;
                    r.stop_offset = stop_pos;
                    r.status      = STATUS_OVERFLOW;
                end
                else
                begin
                    r.value       = negative ? -acc : acc;
                    r.stop_offset = stop_pos;
                    r.status      = STATUS_OK;
                end
                owed_results.push_back(r);
                state = ST_IDLE;
                return;
            end
            // Exact overflow test on a widened product.
            if (!overflowed)
            begin
                wide = 72'(acc) * 72'(radix) + 72'(d);
                if (wide[71:VALUE_WIDTH] != '0)
                begin
                    overflowed = 1'b1;
                end
                else
                begin
                    acc = wide[VALUE_WIDTH-1:0];
                end
            end
            got_digit = 1'b1;
            stop_pos  = sat_step(pos);
        endfunction

        // First character of the number proper, after spaces and sign.
        function void start_number(input logic [CHAR_WIDTH-1:0] c,
                                   input logic [OFFSET_WIDTH-1:0] pos);
            if (c == CHAR_ZERO && (radix == BASE_AUTO || radix == BASE_HEX))
            begin
                got_digit = 1'b1;
                stop_pos  = sat_step(pos);
                state     = ST_ZERO;
            end
            else
            begin
                if (radix == BASE_AUTO)
                begin
                    radix = BASE_DEC;
                end
                state = ST_DIGITS;
                take_digit(c, pos);
            end
        endfunction

        // Advance the parse by one accepted character word.
        function void note_char(input item_t w);
            logic [CHAR_WIDTH-1:0]   c;
            logic [OFFSET_WIDTH-1:0] pos;
            c = w.char_code;
            if (w.string_start)
            begin
                state      = ST_LEAD;
                radix      = base_reg;
                acc        = '0;
                negative   = 1'b0;
                got_digit  = 1'b0;
                overflowed = 1'b0;
                char_pos   = '0;
                stop_pos   = '0;
            end
            if (state == ST_IDLE)
            begin
                return;
            end
            pos = char_pos;
            case (state)
                ST_LEAD:
                begin
                    if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                    begin
                        // Leading whitespace is skipped.
                    end
                    else if (c == CHAR_MINUS)
                    begin
                        negative = 1'b1;
                        state    = ST_AFTER_SIGN;
                    end
                    else if (c == CHAR_PLUS)
                    begin
                        state = ST_AFTER_SIGN;
                    end
                    else
                    begin
                        start_number(c, pos);
                    end
                end
                ST_AFTER_SIGN:
                begin
                    start_number(c, pos);
                end
                ST_ZERO:
                begin
                    if (c == CHAR_LOWER_X || c == CHAR_UPPER_X)
                    begin
                        radix = BASE_HEX;
                        state = ST_DIGITS;
                    end
                    else
                    begin
                        if (radix == BASE_AUTO)
                        begin
                            radix = BASE_OCT;
                        end
                        state = ST_DIGITS;
                        take_digit(c, pos);
                    end
                end
                default:
                begin
                    take_digit(c, pos);
                end
            endcase
            char_pos = sat_step(pos);
        endfunction

        // Compare one accepted result word with the oldest prediction.
        task check_result(input result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("unexpected result word %h", got));
                return;
            end
            want = owed_results.pop_front();
            if (got.value !== want.value)
            begin
                report($sformatf("value expected %h got %h", want.value, got.value));
            end
            if (got.stop_offset !== want.stop_offset)
            begin
                report($sformatf("stop_offset expected %0d got %0d",
                                 want.stop_offset, got.stop_offset));
            end
            if (got.status !== want.status)
            begin
                report($sformatf("status expected %0d got %0d", want.status, got.status));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 item_data    = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result_data;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [BASE_WIDTH-1:0] cfg_data     = '0;

    number_scoreboard sb = new();

    int          burst_left  = 0;
    int          base_words  = 0;
    int          quiet_count = 0;
    int          stall_timer = 0;
    logic [7:0]  stall_mask  = 8'hFF;

    ascii_to_unsigned_integer_parser u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result receiver: check accepted words, then stall on a rotating mask
    // that is redrawn whenever its timer runs out.
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            sb.check_result(result_data);
        end
        if (stall_timer == 0)
        begin
            stall_timer = 48;
            stall_mask  = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        end
        else
        begin
            stall_timer--;
        end
        stall_mask   = {stall_mask[6:0], stall_mask[7]};
        result_ready <= stall_mask[0];
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_count <= 0;
        end
        else if (quiet_count >= QUIET_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Send one character word; the sender runs in bursts with random gaps.
    task automatic send_word(input logic [CHAR_WIDTH-1:0] c, input logic first);
        item_t w;
        int    gap;
        w.char_code    = c;
        w.string_start = first;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_valid <= 1'b1;
        item_data  <= w;
        do @(posedge clk); while (!item_ready);
        sb.note_char(w);
        burst_left--;
        base_words++;
    endtask

    // Send a literal string, optionally closed by a NUL.
    task automatic send_text(input string s, input bit with_nul);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(s[i], i == 0);
        end
        if (with_nul)
        begin
            send_word(8'h00, s.len() == 0);
        end
    endtask

    // Close any open string, then wait until every result word is in.
    task automatic close_and_drain();
        send_word(8'h00, 1'b0);
        item_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [BASE_WIDTH-1:0] b);
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_base(b);
    endtask

    // One random string: mostly well-formed numbers with random content,
    // some raw noise and some strings cut short by the next start.
    task automatic send_random_string(input logic [BASE_WIDTH-1:0] b);
        logic [CHAR_WIDTH-1:0] q[$];
        int                    kind;
        int                    n;
        int                    r;
        int                    d;
        int                    sp;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            n = $urandom_range(1, 10);
            repeat (n) q.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                sp = $urandom_range(8, 13);
                q.push_back((sp == 8) ? CHAR_SPACE : 8'(sp));
            end
            case ($urandom_range(0, 3))
                0: q.push_back(CHAR_MINUS);
                1: q.push_back(CHAR_PLUS);
                default: ;
            endcase
            r = b;
            if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(0, 2) == 0)
            begin
                q.push_back(CHAR_ZERO);
                q.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
                r = 16;
            end
            else if (b == BASE_AUTO)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    q.push_back(CHAR_ZERO);
                    r = 8;
                end
                else
                begin
                    r = 10;
                end
            end
            if (r > 36)
            begin
                r = 36;
            end
            // Long digit runs can drive the accumulator into overflow.
            if ($urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(12, (r <= 4) ? 70 : 30);
            end
            else
            begin
                n = $urandom_range(1, 8);
            end
            repeat (n)
            begin
                d = $urandom_range(0, r - 1);
                if (d < 10)
                begin
                    q.push_back(CHAR_ZERO + 8'(d));
                end
                else
                begin
                    q.push_back(($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A)
                                + 8'(d - 10));
                end
            end
            if (kind != 1)
            begin
                q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
                repeat ($urandom_range(0, 2)) q.push_back(8'($urandom));
            end
        end
        foreach (q[i])
        begin
            send_word(q[i], i == 0);
        end
    endtask

    // Directed strings for the corner cases of each radix setting.
    task automatic send_directed(input logic [BASE_WIDTH-1:0] b);
        case (b)
            BASE_DEC:
            begin
                send_text("0", 1);
                send_text("18446744073709551615", 1);
                send_text("18446744073709551616", 1);
                send_text(" \t\n\v\f\015-42x", 0);
                send_text("+7", 1);
                send_text("-", 1);
                send_text("", 1);
                send_text("-0", 1);
                // A new start drops the string that is still open.
                send_text("12", 0);
                send_text("34", 1);
            end
            BASE_AUTO:
            begin
                send_text("0777", 1);
                send_text("0x7F", 1);
                send_text("089", 1);
                send_text("0X", 1);
                send_text("-0x1A", 1);
                send_text("0xg", 0);
                send_text("123", 1);
            end
            BASE_HEX:
            begin
                send_text("0x1f", 1);
                send_text("0Xg", 0);
                send_text("FFFFFFFFFFFFFFFF", 1);
                send_text("1FFFFFFFFFFFFFFFF", 1);
                send_text("-0x10", 1);
                send_text("fF", 1);
            end
            BASE_OCT:
            begin
                send_text("777", 1);
                send_text("8", 1);
                send_text("-17", 1);
            end
            BASE_LIMIT:
            begin
                send_text("zZ", 1);
                send_text("Zz9", 1);
                send_text("zzzzzzzzzzzzzz", 1);
                send_text("[", 1);
                send_text("{", 1);
                send_text("@", 1);
            end
            BASE_ONE:
            begin
                send_text("000", 1);
                send_text("1", 1);
                send_text("0x0", 1);
            end
            default:
            begin
                send_text("0", 1);
                send_text("z1", 1);
                send_text("-101", 1);
            end
        endcase
    endtask

    // Stimulus.
    initial
    begin
        logic [BASE_WIDTH-1:0] bases[$];
        bases = '{BASE_DEC, BASE_AUTO, BASE_HEX, BASE_OCT, BASE_LIMIT, BASE_ONE,
                  6'd2, 6'd63, 6'd37, 6'($urandom_range(2, 35)), BASE_DEC};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Characters with no string open are ignored.
        send_word(8'hFF, 1'b0);
        send_word(8'h35, 1'b0);
        send_word(8'h00, 1'b0);

        foreach (bases[i])
        begin
            // The first setting is the reset radix and needs no write.
            if (i != 0)
            begin
                write_base(bases[i]);
            end
            send_directed(bases[i]);
            base_words = 0;
            while (base_words < RANDOM_WORDS_PER_BASE)
            begin
                send_random_string(bases[i]);
            end
            close_and_drain();
        end

        if (sb.error_count == 0 && sb.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
